/* rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Sizes of the queue store, command and status codes, and the control word
// that the top level hands to each storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 4;
  localparam int STAT_W = 3;
  localparam int LEN_W  = 5;

  // Count holds 0..DEPTH; the address selects one of DEPTH cells.
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Upper two command bits; the low bit picks head or tail.
  typedef enum logic [1:0] {
    KIND_PUT = 2'd0,
    KIND_GET = 2'd1,
    KIND_ITH = 2'd2,
    KIND_REM = 2'd3
  } op_kind_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_op_t;

  // The same word is the value to load and the key to compare against.
  typedef struct packed {
    cell_op_t op;
    word_t    load_word;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/deq_if.sv */
// ----------------------------------------------------------------------------
// deq_in_if / deq_out_if: command and result channels
// Valid/ready channels; a word moves at a clock edge where both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_in_if import deq_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  command;
  word_t value;
  idx_t  index;

  modport source (output valid, output command, output value, output index,
                  input ready);
  modport sink   (input valid, input command, input value, input index,
                  output ready);
endinterface

interface deq_out_if import deq_pkg::*; ();
  logic    valid;
  logic    ready;
  word_t   data_out;
  status_t status;
  len_t    length;

  modport source (output valid, output data_out, output status, output length,
                  input ready);
  modport sink   (input valid, input data_out, input status, input length,
                  output ready);
endinterface

`default_nettype wire

/* rtl/double_ended_queue_core.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded double-ended queue of data words
// Push, pop, indexed read and remove-by-value at either end, built on a row
// of shifting storage cells.
// ----------------------------------------------------------------------------
// Each accepted command completes at the edge that accepts it: the row of DEPTH
// cells shifts toward the head or the tail, or loads a word, at that edge, and
// remove compares the key in every cell at once, so the block takes one
// command per cycle while the result side does not stall. The result word is in
// the output register in the cycle after acceptance, and a new command is taken
// while that word waits as long as the sink takes it in the same cycle. Errors
// (pop when empty, index out of range, put when full, value not found) are
// reported in status and leave the contents unchanged. No clearing pass runs
// after reset; only the count and the output valid flag are cleared.
`default_nettype none

module double_ended_queue_core import deq_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  deq_in_if.sink      in_deq,
  deq_out_if.source   out_deq
);

  cnt_t       count_r;
  cnt_t       count_nxt;
  logic       out_valid_r;
  word_t      data_r;
  word_t      data_nxt;
  status_t    status_r;
  status_t    status_nxt;
  len_t       length_r;
  logic [WIDE_W-1:0] count_wide;

  logic       accept;
  op_kind_t   kind;
  logic       tail;
  logic       full;
  logic       empty;
  logic       range_err;
  logic       found;

  logic [CMP_W-1:0]  idx_eff;
  logic [CMP_W-1:0]  rd_addr;
  word_t             rd_word;

  word_t             cell_word  [DEPTH];
  logic [DEPTH-1:0]  cell_match;
  logic [DEPTH-1:0]  live_match;
  logic [DEPTH-1:0]  shift_head;
  cell_ctrl_t        cell_ctrl  [DEPTH];

  // No command is taken while reset is held.
  assign in_deq.ready = rst_n && (!out_valid_r || out_deq.ready);
  assign accept       = in_deq.valid && in_deq.ready;
  assign kind         = op_kind_t'(in_deq.command[CMD_W-1:1]);
  assign tail         = in_deq.command[0];
  assign full         = (count_r == CNT_W'(DEPTH));
  assign empty        = (count_r == '0);

  // Row of cells; the head cell takes the incoming word when the row shifts
  // toward the tail, and the last cell keeps its own word when it shifts in.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t prev_w;
    word_t next_w;
    if (g == 0) begin : g_first
      assign prev_w = in_deq.value;
    end else begin : g_mid
      assign prev_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = cell_word[g];
    end else begin : g_inner
      assign next_w = cell_word[g+1];
    end
    deq_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .prev_word (prev_w),
      .next_word (next_w),
      .word      (cell_word[g]),
      .match     (cell_match[g])
    );
  end

  // Matches only count inside the occupied part. A cell at or past the
  // removed position pulls from its neighbor: for a head search that is every
  // cell with a match at or below it, for a tail search every cell with no
  // match above it.
  always_comb begin
    logic [DEPTH-1:0] le_mask;
    for (int k = 0; k < DEPTH; k++) begin
      live_match[k] = cell_match[k] && (CNT_W'(k) < count_r);
    end
    for (int k = 0; k < DEPTH; k++) begin
      for (int j = 0; j < DEPTH; j++) begin
        le_mask[j] = (j <= k);
      end
      if (tail) begin
        shift_head[k] = ~|(live_match & ~le_mask);
      end else begin
        shift_head[k] = |(live_match & le_mask);
      end
    end
  end

  assign found = |live_match;

  // One read port: get reads index zero from its end.
  assign idx_eff   = (kind == KIND_GET) ? '0 : CMP_W'(in_deq.index);
  assign rd_addr   = tail ? (CMP_W'(count_r) - CMP_W'(1) - idx_eff) : idx_eff;
  assign rd_word   = cell_word[rd_addr[ADDR_W-1:0]];
  assign range_err = (CMP_W'(in_deq.index) >= CMP_W'(count_r));

  always_comb begin
    count_nxt  = count_r;
    data_nxt   = '0;
    status_nxt = ST_OK;
    for (int k = 0; k < DEPTH; k++) begin
      cell_ctrl[k].op        = CELL_HOLD;
      cell_ctrl[k].load_word = in_deq.value;
    end
    unique case (kind)
      KIND_PUT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          for (int k = 0; k < DEPTH; k++) begin
            if (!tail) begin
              cell_ctrl[k].op = CELL_FROM_PREV;
            end else if (CNT_W'(k) == count_r) begin
              cell_ctrl[k].op = CELL_LOAD;
            end
          end
        end
      end
      KIND_GET: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          data_nxt  = rd_word;
          if (!tail) begin
            for (int k = 0; k < DEPTH; k++) begin
              cell_ctrl[k].op = CELL_FROM_NEXT;
            end
          end
        end
      end
      KIND_ITH: begin
        if (range_err) begin
          status_nxt = ST_RANGE;
        end else begin
          data_nxt = rd_word;
        end
      end
      KIND_REM: begin
        if (!found) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          data_nxt  = in_deq.value;
          for (int k = 0; k < DEPTH; k++) begin
            if (shift_head[k]) begin
              cell_ctrl[k].op = CELL_FROM_NEXT;
            end
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    if (!accept) begin
      count_nxt = count_r;
      for (int k = 0; k < DEPTH; k++) begin
        cell_ctrl[k].op = CELL_HOLD;
      end
    end
  end

  assign count_wide = WIDE_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_deq.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      data_r   <= data_nxt;
      status_r <= status_nxt;
      length_r <= count_wide[LEN_W-1:0];
    end
  end

  assign out_deq.valid    = out_valid_r;
  assign out_deq.data_out = data_r;
  assign out_deq.status   = status_r;
  assign out_deq.length   = length_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && kind == KIND_PUT && !full |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("successful put did not grow the queue by one");

  a_error_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && status_nxt != ST_OK |=> count_r == $past(count_r))
    else $error("failed command changed the queue length");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && length_r == $past(count_wide[LEN_W-1:0]))
    else $error("result length does not match the updated count");
`endif

endmodule

`default_nettype wire

/* rtl/deq_cell.sv */
// ----------------------------------------------------------------------------
// deq_cell: one storage cell of the queue row
// Holds one word, takes a new one from the load bus or from either neighbor,
// and flags whether its word equals the key on the control bus.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell import deq_pkg::*; (
  input  wire        clk,
  input  cell_ctrl_t ctrl,
  input  word_t      prev_word,
  input  word_t      next_word,
  output word_t      word,
  output logic       match
);

  word_t word_r;
  word_t word_nxt;

  always_comb begin
    case (ctrl.op)
      CELL_LOAD:      word_nxt = ctrl.load_word;
      CELL_FROM_PREV: word_nxt = prev_word;
      CELL_FROM_NEXT: word_nxt = next_word;
      default:        word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word  = word_r;
  assign match = (word_r == ctrl.load_word);

endmodule

`default_nettype wire

/* tb/double_ended_queue_core_test.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_core_test: self-checking bench for the deque core
// A short scripted sequence hits empty, full, out-of-range and not-found
// cases, then random traffic in fill, drain and mixed stretches runs against
// a behavioral deque. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module double_ended_queue_core_test import deq_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 1400;
  localparam int STALL_LIMIT = 4000;
  localparam int N_ROWS      = 25;

  localparam cmd_t HEAD_PUT = {KIND_PUT, 1'b0};
  localparam cmd_t TAIL_PUT = {KIND_PUT, 1'b1};
  localparam cmd_t HEAD_GET = {KIND_GET, 1'b0};
  localparam cmd_t TAIL_GET = {KIND_GET, 1'b1};
  localparam cmd_t HEAD_ITH = {KIND_ITH, 1'b0};
  localparam cmd_t TAIL_ITH = {KIND_ITH, 1'b1};
  localparam cmd_t HEAD_REM = {KIND_REM, 1'b0};
  localparam cmd_t TAIL_REM = {KIND_REM, 1'b1};

  typedef struct packed {
    word_t   data;
    status_t status;
    len_t    length;
  } deq_result_t;

  // One scripted line; reps repeats the command with the value counting up.
  typedef struct packed {
    cmd_t        cmd;
    word_t       val;
    idx_t        idx;
    logic [4:0]  reps;
    bit          fixed;
    deq_result_t res;
  } deq_row_t;

  typedef enum int {SINK_OPEN, SINK_MOSTLY, SINK_SPARSE, SINK_RUNS} sink_mode_t;
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

  localparam deq_result_t NO_RES = '0;

  localparam deq_row_t script [0:N_ROWS-1] = '{
    '{HEAD_GET, 32'h0,         4'd0,  5'd1,  1'b1, '{32'h0, ST_EMPTY,    5'd0}},
    '{TAIL_GET, 32'h0,         4'd0,  5'd1,  1'b1, '{32'h0, ST_EMPTY,    5'd0}},
    '{HEAD_ITH, 32'h0,         4'd0,  5'd1,  1'b1, '{32'h0, ST_RANGE,    5'd0}},
    '{TAIL_ITH, 32'h0,         4'd15, 5'd1,  1'b1, '{32'h0, ST_RANGE,    5'd0}},
    '{HEAD_REM, 32'h0,         4'd0,  5'd1,  1'b1, '{32'h0, ST_NOTFOUND, 5'd0}},
    '{TAIL_REM, 32'hFFFF_FFFF, 4'd0,  5'd1,  1'b1, '{32'h0, ST_NOTFOUND, 5'd0}},
    '{TAIL_PUT, 32'hFFFF_FFFF, 4'd0,  5'd1,  1'b1, '{32'h0, ST_OK,       5'd1}},
    '{HEAD_PUT, 32'h0,         4'd0,  5'd1,  1'b1, '{32'h0, ST_OK,       5'd2}},
    '{HEAD_ITH, 32'h0,         4'd0,  5'd1,  1'b0, NO_RES},
    '{TAIL_ITH, 32'h0,         4'd0,  5'd1,  1'b0, NO_RES},
    '{TAIL_ITH, 32'h0,         4'd2,  5'd1,  1'b1, '{32'h0, ST_RANGE,    5'd2}},
    '{TAIL_PUT, 32'hA5A5_0000, 4'd0,  5'd14, 1'b0, NO_RES},
    '{HEAD_PUT, 32'h0000_1234, 4'd0,  5'd1,  1'b1, '{32'h0, ST_FULL,     5'd16}},
    '{TAIL_PUT, 32'hFFFF_FFFF, 4'd0,  5'd1,  1'b1, '{32'h0, ST_FULL,     5'd16}},
    '{TAIL_ITH, 32'h0,         4'd15, 5'd1,  1'b0, NO_RES},
    '{HEAD_ITH, 32'h0,         4'd15, 5'd1,  1'b0, NO_RES},
    '{HEAD_REM, 32'hFFFF_FFFF, 4'd0,  5'd1,  1'b0, NO_RES},
    '{TAIL_REM, 32'hA5A5_0007, 4'd0,  5'd1,  1'b0, NO_RES},
    '{HEAD_REM, 32'hDEAD_BEEF, 4'd0,  5'd1,  1'b1, '{32'h0, ST_NOTFOUND, 5'd14}},
    '{HEAD_GET, 32'h0,         4'd0,  5'd1,  1'b0, NO_RES},
    '{TAIL_GET, 32'h0,         4'd0,  5'd1,  1'b0, NO_RES},
    '{HEAD_PUT, 32'h5555_AAAA, 4'd0,  5'd1,  1'b0, NO_RES},
    '{TAIL_PUT, 32'h5555_AAAA, 4'd0,  5'd1,  1'b0, NO_RES},
    '{TAIL_REM, 32'h5555_AAAA, 4'd0,  5'd1,  1'b0, NO_RES},
    '{HEAD_REM, 32'h5555_AAAA, 4'd0,  5'd1,  1'b0, NO_RES}
  };

  logic clk;
  logic rst_n;

  deq_in_if  in_bus ();
  deq_out_if out_bus ();

  double_ended_queue_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_deq  (in_bus.sink),
    .out_deq (out_bus.source)
  );

  // Behavioral copy of the deque; slot 0 is the head.
  word_t dq_words [DEPTH];
  int    dq_count;

  deq_result_t pending_results [$];
  bit          fixed_on;
  deq_result_t fixed_res;
  int          err_count;
  int          results_seen;
  int          burst_left;
  int          idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= 100)
      $display("MISMATCH result %0d %s: got %h, want %h", results_seen, what, got, want);
  endtask

  function automatic void remove_word_at(input int at);
    int k;
    for (k = at; k + 1 < dq_count; k++)
      dq_words[k] = dq_words[k + 1];
    dq_count--;
  endfunction

  function automatic deq_result_t predict_deque(input cmd_t cmd, input word_t val,
                                                input idx_t idx);
    deq_result_t r;
    logic        at_tail;
    int          k;
    int          pos;
    bit          found;
    r.data   = '0;
    r.status = ST_OK;
    at_tail  = cmd[0];
    case (op_kind_t'(cmd[CMD_W-1:1]))
      KIND_PUT: begin
        if (dq_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (at_tail) begin
          dq_words[dq_count] = val;
          dq_count++;
        end else begin
          for (k = dq_count; k > 0; k--)
            dq_words[k] = dq_words[k - 1];
          dq_words[0] = val;
          dq_count++;
        end
      end
      KIND_GET: begin
        if (dq_count == 0) begin
          r.status = ST_EMPTY;
        end else if (at_tail) begin
          r.data = dq_words[dq_count - 1];
          dq_count--;
        end else begin
          r.data = dq_words[0];
          remove_word_at(0);
        end
      end
      KIND_ITH: begin
        if (int'(idx) >= dq_count)
          r.status = ST_RANGE;
        else
          r.data = at_tail ? dq_words[dq_count - 1 - int'(idx)] : dq_words[idx];
      end
      default: begin
        r.status = ST_NOTFOUND;
        found    = 1'b0;
        for (k = 0; k < dq_count && !found; k++) begin
          pos = at_tail ? (dq_count - 1 - k) : k;
          if (dq_words[pos] == val) begin
            r.data   = val;
            r.status = ST_OK;
            found    = 1'b1;
            remove_word_at(pos);
          end
        end
      end
    endcase
    r.length = len_t'(dq_count);
    return r;
  endfunction

  // Entered at a falling edge, returns at the falling edge after acceptance.
  task automatic send_word(input cmd_t c, input word_t v, input idx_t i,
                           input bit fixed, input deq_result_t fx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(7, 20);
      if (gap > 0) begin
        in_bus.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_bus.valid   = 1'b1;
    in_bus.command = c;
    in_bus.value   = v;
    in_bus.index   = i;
    fixed_on       = fixed;
    fixed_res      = fx;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  // Predict on every accepted command word, check every accepted result word.
  always @(posedge clk) begin : monitor
    deq_result_t model_res;
    deq_result_t want;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        model_res = predict_deque(in_bus.command, in_bus.value, in_bus.index);
        pending_results.push_back(fixed_on ? fixed_res : model_res);
      end
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", out_bus.data_out, 32'h0);
        end else begin
          want = pending_results.pop_front();
          if (out_bus.data_out !== want.data)
            report_mismatch("data_out", out_bus.data_out, want.data);
          if (out_bus.status !== want.status)
            report_mismatch("status", 32'(out_bus.status), 32'(want.status));
          if (out_bus.length !== want.length)
            report_mismatch("length", 32'(out_bus.length), 32'(want.length));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : result_sink
    sink_mode_t mode;
    int         left;
    int         run;
    out_bus.ready = 1'b0;
    mode = SINK_OPEN;
    left = 0;
    run  = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        left = $urandom_range(40, 200);
      end
      left--;
      case (mode)
        SINK_OPEN:   out_bus.ready = 1'b1;
        SINK_MOSTLY: out_bus.ready = ($urandom_range(0, 3) != 0);
        SINK_SPARSE: out_bus.ready = ($urandom_range(0, 3) == 0);
        default: begin
          // Alternating runs of stall and runs of take, each of random length.
          if (run == 0) begin
            out_bus.ready = !out_bus.ready;
            run = $urandom_range(1, 12);
          end
          run--;
        end
      endcase
    end
  end

  initial begin : command_source
    int           row;
    int           rep;
    int           n;
    int           pick;
    int           mix_left;
    traffic_mix_t mix;
    op_kind_t     kind;
    cmd_t         c;
    word_t        v;
    idx_t         ix;
    in_bus.valid   = 1'b0;
    in_bus.command = HEAD_PUT;
    in_bus.value   = '0;
    in_bus.index   = '0;
    fixed_on       = 1'b0;
    fixed_res      = NO_RES;
    err_count      = 0;
    results_seen   = 0;
    burst_left     = 0;
    idle_cycles    = 0;
    dq_count       = 0;
    mix            = MIX_FILL;
    mix_left       = 0;
    rst_n          = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    for (row = 0; row < N_ROWS; row++)
      for (rep = 0; rep < int'(script[row].reps); rep++)
        send_word(script[row].cmd, script[row].val + word_t'(rep), script[row].idx,
                  script[row].fixed, script[row].res);

    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 2) begin
        // Let the result side run dry once before carrying on.
        in_bus.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      if (mix_left == 0) begin
        mix      = traffic_mix_t'($urandom_range(0, 2));
        mix_left = $urandom_range(60, 150);
      end
      mix_left--;
      pick = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:  kind = pick < 55 ? KIND_PUT : pick < 65 ? KIND_GET :
                          pick < 85 ? KIND_ITH : KIND_REM;
        MIX_DRAIN: kind = pick < 20 ? KIND_PUT : pick < 60 ? KIND_GET :
                          pick < 80 ? KIND_ITH : KIND_REM;
        default:   kind = pick < 30 ? KIND_PUT : pick < 55 ? KIND_GET :
                          pick < 78 ? KIND_ITH : KIND_REM;
      endcase
      c = {kind, 1'($urandom_range(0, 1))};
      pick = $urandom_range(0, 9);
      if (kind == KIND_REM && dq_count > 0 && pick < 7)
        v = dq_words[$urandom_range(0, dq_count - 1)];
      else if (pick < 4)
        v = $urandom();
      else if (pick < 8)
        v = 32'hC0DE_0000 + word_t'($urandom_range(0, 7));
      else
        v = (pick == 8) ? 32'h0 : 32'hFFFF_FFFF;
      if (dq_count > 0 && $urandom_range(0, 4) != 0)
        ix = idx_t'($urandom_range(0, dq_count - 1));
      else
        ix = idx_t'($urandom_range(0, 15));
      send_word(c, v, ix, 1'b0, NO_RES);
    end

    in_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
